@@ hdl/mrt_pkg.sv @@
// Package: shared types and constants for the message retry table.
`timescale 1ns / 1ps
package mrt_pkg;
  localparam int CALL_W = 40;
  localparam int STAMP_W = 32;
  localparam logic [16:0] AHEAD_SECONDS = 17'd86400;
  localparam logic [7:0] RETRIES_ACKED = 8'hFE;
  localparam int MAX_REPORTS = 16;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_ACK    = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NODUE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_TRD,
    S_TEV,
    S_READ,
    S_RDATA,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CALL_W-1:0] call_hi;
    logic [CALL_W-1:0] call_lo;
    logic [15:0] msg_id;
    logic direction;
    logic [7:0] retries;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  function automatic logic [2*CALL_W-1:0] normalize_call(logic [2*CALL_W-1:0] c);
    logic [2*CALL_W-1:0] r;
    logic ended;
    r = c;
    ended = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (ended) r[(9-k)*8 +: 8] = 8'd0;
      else if (c[(9-k)*8 +: 8] == 8'd0) ended = 1'b1;
    end
    return r;
  endfunction
endpackage

@@ hdl/message_retry_table_top.sv @@
// Top level: message retry table with entries held in one synchronous memory.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   mode .. entry_index
//   out      out_valid  out_stall  status .. last
//   cfg      cfg_we     -          cfg_data (retry_interval)
//
// Record and ack read every entry, one per cycle, then write back. Tick reads
// each entry and then evaluates and writes it back; earlier reports wait at the
// output before the scan goes on. Read fetches one entry from memory. Rejects
// and out-of-range reads go straight to the output. Reset is synchronous;
// entries read as zero until written (valid flops). One item at a time;
// in_stall is high until the final result transfers.
`timescale 1ns / 1ps
module message_retry_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] mode,
  input  logic [39:0] call_hi,
  input  logic [39:0] call_lo,
  input  logic [15:0] msg_id,
  input  logic direction,
  input  logic signed [7:0] retries_init,
  input  logic [7:0] text_length,
  input  logic [31:0] now,
  input  logic [5:0] entry_index,
  input  logic cfg_we,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [5:0] slot,
  output logic [39:0] out_call_hi,
  output logic [39:0] out_call_lo,
  output logic [15:0] out_msg_id,
  output logic out_direction,
  output logic signed [7:0] retries_left,
  output logic [31:0] stamp,
  output logic last
);
  import mrt_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  entry_t rd_raw, rd;
  logic rd_vld;
  logic [AW-1:0] rd_addr;
  logic rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (rd_en) rd_vld <= vld[rd_addr];
    end
  end
  assign rd = rd_vld ? rd_raw : '0;

  state_t state, state_next;
  logic [15:0] retry_interval;
  mode_t q_mode;
  logic [2*CALL_W-1:0] q_call;
  logic [15:0] q_id;
  logic q_dir;
  logic [7:0] q_rinit;
  logic [31:0] q_now;
  logic [5:0] q_idx;
  logic [CW-1:0] cnt;
  logic pend;
  logic [AW-1:0] pend_addr;
  logic found;
  logic [AW-1:0] found_idx;
  logic old_ok;
  logic [AW-1:0] old_idx;
  logic [32:0] old_min;
  logic [6:0] reports;
  logic held_any;
  logic [AW-1:0] held_addr;
  entry_t held_ent;
  logic tick_more;

  status_t o_status;
  logic [5:0] o_slot;
  entry_t o_ent;
  logic o_last;

  always_ff @(posedge clk) begin
    if (rst) retry_interval <= 16'd60;
    else if (cfg_we) retry_interval <= cfg_data;
  end

  logic accept;
  logic reject_in;
  logic idx_ok;
  logic tick_end;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign idx_ok = {1'b0, entry_index} < 7'(TABLE_DEPTH);
  assign reject_in = (mode == MODE_RECORD || mode == MODE_ACK) &&
                     (call_hi[39:32] == 8'd0 ||
                      (mode == MODE_RECORD && text_length == 8'd0));
  assign tick_end = (cnt == LAST_CNT) || (reports == 7'(MAX_REPORTS));

  logic match;
  logic due;
  logic signed [32:0] age;
  logic [7:0] r_dec;
  logic [32:0] nstamp;
  entry_t tick_ent;
  entry_t rec_ent;
  assign match = rd.call_hi == q_call[2*CALL_W-1:CALL_W] &&
                 rd.call_lo == q_call[CALL_W-1:0] &&
                 rd.msg_id == q_id &&
                 rd.direction == ((q_mode == MODE_ACK) ? 1'b0 : q_dir);
  assign age = $signed({1'b0, q_now}) - $signed({1'b0, rd.stamp});
  assign due = ($signed(rd.retries) > 8'sd0) &&
               (age > $signed({17'd0, retry_interval}));
  assign r_dec = rd.retries - 8'd1;
  assign nstamp = {1'b0, q_now} + {17'd0, retry_interval};

  always_comb begin
    tick_ent = rd;
    tick_ent.retries = r_dec;
    if ($signed(r_dec) > 8'sd0) tick_ent.stamp = nstamp[32] ? 32'hFFFF_FFFF : nstamp[31:0];
  end

  always_comb begin
    rec_ent = o_ent;
    if (q_mode == MODE_ACK) begin
      rec_ent.retries = RETRIES_ACKED;
    end else begin
      rec_ent.call_hi = q_call[2*CALL_W-1:CALL_W];
      rec_ent.call_lo = q_call[CALL_W-1:0];
      rec_ent.msg_id = q_id;
      rec_ent.direction = q_dir;
      rec_ent.retries = q_rinit;
      rec_ent.stamp = q_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = cnt[AW-1:0];
    wr_en = 1'b0;
    wr_addr = pend_addr;
    wr_data = tick_ent;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (reject_in || (mode == MODE_READ && !idx_ok)) state_next = S_OUT;
          else if (mode == MODE_TICK) state_next = S_TRD;
          else if (mode == MODE_READ) state_next = S_READ;
          else state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = (cnt != LAST_CNT);
        if (!pend && cnt == LAST_CNT) state_next = S_WRITE;
      end
      S_WRITE: begin
        wr_en = found;
        wr_addr = found_idx;
        wr_data = rec_ent;
        state_next = S_OUT;
      end
      S_TRD: begin
        if (tick_end) begin
          state_next = S_OUT;
        end else begin
          rd_en = 1'b1;
          state_next = S_TEV;
        end
      end
      S_TEV: begin
        wr_en = due;
        state_next = (due && held_any) ? S_OUT : S_TRD;
      end
      S_READ: begin
        rd_en = 1'b1;
        rd_addr = q_idx[AW-1:0];
        state_next = S_RDATA;
      end
      S_RDATA: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = tick_more ? S_TRD : S_IDLE;
    endcase
  end

  assign out_valid = (state == S_OUT);
  assign status = o_status;
  assign slot = o_slot;
  assign out_call_hi = o_ent.call_hi;
  assign out_call_lo = o_ent.call_lo;
  assign out_msg_id = o_ent.msg_id;
  assign out_direction = o_ent.direction;
  assign retries_left = o_ent.retries;
  assign stamp = o_ent.stamp;
  assign last = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      held_any <= 1'b0;
      tick_more <= 1'b0;
    end else begin
      pend <= rd_en;
      if (rd_en) pend_addr <= rd_addr;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_mode <= mode_t'(mode);
            q_call <= normalize_call({call_hi, call_lo});
            q_id <= msg_id;
            q_dir <= direction;
            q_rinit <= retries_init;
            q_now <= now;
            q_idx <= entry_index;
            cnt <= '0;
            found <= 1'b0;
            old_ok <= 1'b0;
            old_min <= {1'b0, now} + {16'd0, AHEAD_SECONDS};
            reports <= '0;
            held_any <= 1'b0;
            tick_more <= 1'b0;
            o_ent <= '0;
            o_slot <= (mode == MODE_READ) ? entry_index : 6'd0;
            o_last <= 1'b1;
            if (reject_in) o_status <= ST_REJECT;
            else if (mode == MODE_READ && !idx_ok) o_status <= ST_NOTFOUND;
            else o_status <= ST_OK;
          end
        end
        S_SCAN: begin
          if (rd_en) cnt <= cnt + CW'(1);
          if (pend) begin
            if (match && !found) begin
              found <= 1'b1;
              found_idx <= pend_addr;
              o_ent <= rd;
            end
            if ({1'b0, rd.stamp} < old_min) begin
              old_min <= {1'b0, rd.stamp};
              old_idx <= pend_addr;
              old_ok <= 1'b1;
            end
          end else if (cnt == LAST_CNT && !found && q_mode == MODE_RECORD && old_ok) begin
            found <= 1'b1;
            found_idx <= old_idx;
          end
        end
        S_WRITE: begin
          if (found) begin
            o_status <= ST_OK;
            o_slot <= 6'(found_idx);
            o_ent <= rec_ent;
          end else begin
            o_status <= (q_mode == MODE_ACK) ? ST_NOTFOUND : ST_REJECT;
            o_slot <= '0;
            o_ent <= '0;
          end
        end
        S_TRD: begin
          if (tick_end) begin
            tick_more <= 1'b0;
            held_any <= 1'b0;
            o_last <= 1'b1;
            if (held_any) begin
              o_status <= ST_OK;
              o_slot <= 6'(held_addr);
              o_ent <= held_ent;
            end else begin
              o_status <= ST_NODUE;
              o_slot <= '0;
              o_ent <= '0;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_TEV: begin
          // a report leaves only once the next one is known, so last is exact
          if (due) begin
            reports <= reports + 7'd1;
            held_any <= 1'b1;
            held_addr <= pend_addr;
            held_ent <= tick_ent;
            if (held_any) begin
              o_status <= ST_OK;
              o_slot <= 6'(held_addr);
              o_ent <= held_ent;
              o_last <= 1'b0;
              tick_more <= 1'b1;
            end
          end
        end
        S_READ: ;
        S_RDATA: o_ent <= rd;
        S_OUT: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot) &&
      $stable(stamp) && $stable(last) && $stable(retries_left));
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({status, slot, last}));
`endif
endmodule
